[src/tbmmc_pkg.sv]
// Package for the two-button motor mode controller.
// Holds the direction and register codes, reset values, the qualifier state
// type and the per-button qualifier step function. No dependencies.
package tbmmc_pkg;

	// direction state codes
	localparam logic [1:0] DIR_CCW  = 2'd0;
	localparam logic [1:0] DIR_STOP = 2'd1;
	localparam logic [1:0] DIR_CW   = 2'd2;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_QUALIFY_TICKS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_POWER_STEP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_POWER_LIMIT   = 3'd3;

	// register reset values
	localparam logic [7:0] QUALIFY_TICKS_RST = 8'd4;
	localparam logic [7:0] WINDOW_TICKS_RST  = 8'd4;
	localparam logic [6:0] POWER_STEP_RST    = 7'd5;
	localparam logic [6:0] POWER_LIMIT_RST   = 7'd100;

	// led bit positions
	localparam int unsigned LED_BIT_RED   = 0;
	localparam int unsigned LED_BIT_GREEN = 1;
	localparam int unsigned LED_BIT_BLUE  = 2;

	typedef struct packed {
		logic       prev;
		logic       active;
		logic       phase;
		logic [7:0] count;
	} qual_t;

	typedef struct packed {
		qual_t q;
		logic  hit;
	} qual_res_t;

	localparam qual_t QUAL_RST = '{prev: 1'b1, active: 1'b0, phase: 1'b0, count: 8'd0};

	// One tick of a two-phase press qualifier; hit flags a confirmed press.
	function automatic qual_res_t qual_step(qual_t q, logic level, logic [7:0] qt);
		qual_res_t r;
		r.q   = q;
		r.hit = 1'b0;
		if (q.prev && !level) begin
			// falling edge: restart, phase kept
			r.q.count  = 8'd0;
			r.q.active = 1'b1;
		end else if (q.active) begin
			if (!level || q.phase) begin
				if (q.count != 8'hFF) begin
					r.q.count = q.count + 8'd1;
				end
			end else begin
				r.q.active = 1'b0;
			end
			if (r.q.count >= qt) begin
				if (q.phase) begin
					r.q.phase  = 1'b0;
					r.q.active = 1'b0;
					r.hit      = 1'b1;
				end else begin
					r.q.count = 8'd0;
					r.q.phase = 1'b1;
				end
			end
		end
		r.q.prev = level;
		return r;
	endfunction

endpackage

[src/two_button_motor_mode_controller_top.sv]
// Ticks go via the input and state registers; one tick per cycle unless the result stalls.
// The tick is captured in an input register; the next-state logic between it and the
// state registers (which double as the result register) is a single short pass.
// A stalled result holds the input register; the input stalls only when both are full.
// Reset (arst_n low, asynchronous) clears the beats, loads register defaults,
// puts the motor in rotation mode at stop with zero power and all LEDs off.
module two_button_motor_mode_controller_top (
	input  logic                             clk,
	input  logic                             arst_n,
	// tick input
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             level_a,
	input  logic                             level_b,
	// result output
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             drive_in1,
	output logic                             drive_in2,
	output logic [7:0]                       pwm_duty,
	output logic [6:0]                       power_percent,
	output logic                             red_led,
	output logic                             green_led,
	output logic                             blue_led,
	output logic                             turn_mode,
	// configuration writes
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tbmmc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [7:0]                       cfg_data
);

	// configuration registers
	logic [7:0] qualify_ticks_q;
	logic [7:0] window_ticks_q;
	logic [6:0] power_step_q;
	logic [6:0] power_limit_q;

	// input stage
	logic valid_s1;
	logic level_a_s1;
	logic level_b_s1;

	// controller state
	tbmmc_pkg::qual_t qual_a_q, qual_b_q;
	logic [1:0] flags_q;
	logic [7:0] win_q;
	logic       mode_q;
	logic [1:0] dir_q;
	logic [6:0] pwr_q;
	logic [2:0] led_q;
	logic       out_valid_q;

	// next state
	tbmmc_pkg::qual_t qual_a_d, qual_b_d;
	tbmmc_pkg::qual_res_t res_a, res_b;
	logic [1:0] flags_d;
	logic [7:0] win_d;
	logic       mode_d;
	logic [1:0] dir_d;
	logic [6:0] pwr_d;
	logic [2:0] led_d;
	logic [7:0] psum;
	logic [1:0] target;

	logic advance;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && out_valid_q && out_stall;

	// configuration write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qualify_ticks_q <= tbmmc_pkg::QUALIFY_TICKS_RST;
			window_ticks_q  <= tbmmc_pkg::WINDOW_TICKS_RST;
			power_step_q    <= tbmmc_pkg::POWER_STEP_RST;
			power_limit_q   <= tbmmc_pkg::POWER_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tbmmc_pkg::REG_QUALIFY_TICKS: qualify_ticks_q <= cfg_data;
				tbmmc_pkg::REG_WINDOW_TICKS:  window_ticks_q  <= cfg_data;
				tbmmc_pkg::REG_POWER_STEP:    power_step_q    <= cfg_data[6:0];
				tbmmc_pkg::REG_POWER_LIMIT:   power_limit_q   <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			level_a_s1 <= level_a;
			level_b_s1 <= level_b;
		end
	end

	// next-state logic for one tick: window expiry first, then both qualifiers
	always_comb begin
		win_d   = win_q;
		flags_d = flags_q;
		mode_d  = mode_q;
		dir_d   = dir_q;
		pwr_d   = pwr_q;
		led_d   = led_q;
		psum    = {1'b0, pwr_q} + {1'b0, power_step_q};
		target  = flags_q[0] ? tbmmc_pkg::DIR_CCW : tbmmc_pkg::DIR_CW;

		if (win_q != 8'd0) begin
			win_d = win_q - 8'd1;
			if (win_d == 8'd0) begin
				if (flags_q[0] && flags_q[1]) begin
					// both buttons: swap mode, LEDs show it
					mode_d = !mode_q;
					led_d[tbmmc_pkg::LED_BIT_GREEN] = mode_d;
					led_d[tbmmc_pkg::LED_BIT_BLUE]  = !mode_d;
				end else if (flags_q[0] || flags_q[1]) begin
					if (mode_q) begin
						// direction command, through stop
						if (dir_q != tbmmc_pkg::DIR_STOP) begin
							dir_d = tbmmc_pkg::DIR_STOP;
						end else begin
							dir_d = target;
							led_d[tbmmc_pkg::LED_BIT_GREEN] = mode_q;
							led_d[tbmmc_pkg::LED_BIT_BLUE]  = !mode_q;
						end
						led_d[tbmmc_pkg::LED_BIT_RED] = !led_q[tbmmc_pkg::LED_BIT_RED];
					end else if (flags_q[0]) begin
						// raise, saturate at limit
						if (psum > {1'b0, power_limit_q}) begin
							pwr_d = power_limit_q;
						end else begin
							pwr_d = psum[6:0];
						end
					end else if (pwr_q >= power_step_q) begin
						pwr_d = pwr_q - power_step_q;
					end else begin
						pwr_d = 7'd0;
					end
				end
				flags_d = 2'b00;
			end
		end

		res_a    = tbmmc_pkg::qual_step(qual_a_q, level_a_s1, qualify_ticks_q);
		res_b    = tbmmc_pkg::qual_step(qual_b_q, level_b_s1, qualify_ticks_q);
		qual_a_d = res_a.q;
		qual_b_d = res_b.q;
		if (res_a.hit) begin
			flags_d[0] = 1'b1;
			win_d      = window_ticks_q;
		end
		if (res_b.hit) begin
			flags_d[1] = 1'b1;
			win_d      = window_ticks_q;
		end
	end

	// state registers, also the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qual_a_q    <= tbmmc_pkg::QUAL_RST;
			qual_b_q    <= tbmmc_pkg::QUAL_RST;
			flags_q     <= 2'b00;
			win_q       <= 8'd0;
			mode_q      <= 1'b1;
			dir_q       <= tbmmc_pkg::DIR_STOP;
			pwr_q       <= 7'd0;
			led_q       <= 3'b000;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				qual_a_q <= qual_a_d;
				qual_b_q <= qual_b_d;
				flags_q  <= flags_d;
				win_q    <= win_d;
				mode_q   <= mode_d;
				dir_q    <= dir_d;
				pwr_q    <= pwr_d;
				led_q    <= led_d;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result beat decode
	assign out_valid     = out_valid_q;
	assign drive_in1     = (dir_q == tbmmc_pkg::DIR_CW);
	assign drive_in2     = (dir_q == tbmmc_pkg::DIR_CCW);
	assign pwm_duty      = {pwr_q, 1'b0};
	assign power_percent = pwr_q;
	assign red_led       = led_q[tbmmc_pkg::LED_BIT_RED];
	assign green_led     = led_q[tbmmc_pkg::LED_BIT_GREEN];
	assign blue_led      = led_q[tbmmc_pkg::LED_BIT_BLUE];
	assign turn_mode     = mode_q;

endmodule

[src/tbmmc_chk.sv]
// Port-level checker for the two-button motor mode controller, with its bind.
// Depends on two_button_motor_mode_controller_top.
module tbmmc_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic                             drive_in1,
	input logic                             drive_in2,
	input logic [7:0]                       pwm_duty,
	input logic [6:0]                       power_percent,
	input logic                             red_led,
	input logic                             green_led,
	input logic                             blue_led,
	input logic                             turn_mode
);

	// a stalled result beat stays and holds its duty, drive, red LED and mode
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pwm_duty) && $stable(red_led)
			&& $stable(drive_in1) && $stable(drive_in2) && $stable(turn_mode))
		else $error("stalled result beat changed");

	// input backs up only behind a stalled result beat
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled result beat");

	// bridge is never driven both ways
	a_drive_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(drive_in1 && drive_in2))
		else $error("both bridge inputs high");

	// duty follows power
	a_duty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pwm_duty == {power_percent, 1'b0})
		else $error("pwm duty does not match power");

	// mode LEDs are never lit together
	a_mode_leds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(green_led && blue_led))
		else $error("green and blue LEDs both lit");

endmodule

bind two_button_motor_mode_controller_top tbmmc_chk u_tbmmc_chk (.*);

[tb/tb.sv]
// Self-checking testbench for the two-button motor mode controller.
// Feeds tick beats of button levels and checks every result beat against an in-bench predictor.
// Depends on tbmmc_pkg and two_button_motor_mode_controller_top.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BTN_A       = 0;
	localparam int BTN_B       = 1;
	localparam int HOLD_CYCLES = 60;
	localparam int CYCLE_LIMIT = 400000;

	// one result beat, field by field
	typedef struct packed {
		logic       drive_in1;
		logic       drive_in2;
		logic [7:0] pwm_duty;
		logic [6:0] power_percent;
		logic       red_led;
		logic       green_led;
		logic       blue_led;
		logic       turn_mode;
	} motor_outputs_t;

	// press qualifier state of one button
	typedef struct {
		bit       prev;
		bit       active;
		bit       phase;
		bit [7:0] count;
	} press_qual_t;

	// Tracks the controller state tick by tick and holds the outputs still owed.
	class motor_state_tracker;
		bit [7:0]       qual_len;
		bit [7:0]       window_len;
		bit [6:0]       step_pct;
		bit [6:0]       limit_pct;
		press_qual_t    qual[2];
		bit [1:0]       press_flags;
		bit [8:0]       window_left;
		bit             rot_mode;
		logic [1:0]     dir;
		bit [6:0]       power;
		bit [2:0]       leds;
		motor_outputs_t expected_outputs[$];
		int             errors;

		function new();
			qual_len    = tbmmc_pkg::QUALIFY_TICKS_RST;
			window_len  = tbmmc_pkg::WINDOW_TICKS_RST;
			step_pct    = tbmmc_pkg::POWER_STEP_RST;
			limit_pct   = tbmmc_pkg::POWER_LIMIT_RST;
			foreach (qual[i]) begin
				qual[i].prev   = 1'b1;
				qual[i].active = 1'b0;
				qual[i].phase  = 1'b0;
				qual[i].count  = 8'd0;
			end
			press_flags = '0;
			window_left = '0;
			rot_mode    = 1'b1;
			dir         = tbmmc_pkg::DIR_STOP;
			power       = '0;
			leds        = '0;
			errors      = 0;
		endfunction

		function void set_reg(logic [tbmmc_pkg::CFG_IDX_W-1:0] idx, logic [7:0] data);
			case (idx)
				tbmmc_pkg::REG_QUALIFY_TICKS: qual_len = data;
				tbmmc_pkg::REG_WINDOW_TICKS: window_len = data;
				tbmmc_pkg::REG_POWER_STEP: step_pct = data[6:0];
				tbmmc_pkg::REG_POWER_LIMIT: limit_pct = data[6:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_outputs.size();
		endfunction

		// green in rotation mode, blue in power mode; red untouched
		function void show_mode();
			leds[tbmmc_pkg::LED_BIT_GREEN] = rot_mode;
			leds[tbmmc_pkg::LED_BIT_BLUE]  = ~rot_mode;
		endfunction

		// a moving motor stops; a stopped one starts toward target
		function void steer(logic [1:0] target);
			if (dir != tbmmc_pkg::DIR_STOP) begin
				dir = tbmmc_pkg::DIR_STOP;
			end else begin
				dir = target;
				show_mode();
			end
			leds[tbmmc_pkg::LED_BIT_RED] = ~leds[tbmmc_pkg::LED_BIT_RED];
		endfunction

		// two-phase qualifier of one button
		function void qualify(int btn, bit lvl);
			if (qual[btn].prev && !lvl) begin
				qual[btn].count  = 8'd0;
				qual[btn].active = 1'b1;
			end else if (qual[btn].active) begin
				if (!lvl || qual[btn].phase) begin
					if (qual[btn].count != 8'hFF) qual[btn].count++;
				end else begin
					qual[btn].active = 1'b0;
				end
				if (qual[btn].count >= qual_len) begin
					if (qual[btn].phase) begin
						qual[btn].phase    = 1'b0;
						qual[btn].active   = 1'b0;
						press_flags[btn]   = 1'b1;
						window_left        = {1'b0, window_len};
					end else begin
						qual[btn].count = 8'd0;
						qual[btn].phase = 1'b1;
					end
				end
			end
			qual[btn].prev = lvl;
		endfunction

		// accepted tick beat: advance the state and queue the outputs it leads to
		function void note_tick(bit la, bit lb);
			int unsigned    sum;
			motor_outputs_t o;
			if (window_left != 0) begin
				window_left--;
				if (window_left == 0) begin
					if (press_flags[BTN_A] && press_flags[BTN_B]) begin
						rot_mode = ~rot_mode;
						show_mode();
					end else if (press_flags[BTN_A]) begin
						if (rot_mode) begin
							steer(tbmmc_pkg::DIR_CCW);
						end else begin
							sum = power + step_pct;
							if (sum > limit_pct) sum = limit_pct;
							power = 7'(sum);
						end
					end else if (press_flags[BTN_B]) begin
						if (rot_mode) begin
							steer(tbmmc_pkg::DIR_CW);
						end else if (power >= step_pct) begin
							power = power - step_pct;
						end else begin
							power = '0;
						end
					end
					press_flags = '0;
				end
			end
			qualify(BTN_A, la);
			qualify(BTN_B, lb);
			o.drive_in1     = (dir == tbmmc_pkg::DIR_CW);
			o.drive_in2     = (dir == tbmmc_pkg::DIR_CCW);
			o.pwm_duty      = {power, 1'b0};
			o.power_percent = power;
			o.red_led       = leds[tbmmc_pkg::LED_BIT_RED];
			o.green_led     = leds[tbmmc_pkg::LED_BIT_GREEN];
			o.blue_led      = leds[tbmmc_pkg::LED_BIT_BLUE];
			o.turn_mode     = rot_mode;
			expected_outputs.push_back(o);
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			end
		endfunction

		// accepted result beat against the oldest owed outputs
		function void check_outputs(motor_outputs_t got);
			motor_outputs_t want;
			if (expected_outputs.size() == 0) begin
				errors++;
				$display("%0t: result beat with nothing expected, got %h", $time, got);
				return;
			end
			want = expected_outputs.pop_front();
			compare_field("drive_in1", 8'(want.drive_in1), 8'(got.drive_in1));
			compare_field("drive_in2", 8'(want.drive_in2), 8'(got.drive_in2));
			compare_field("pwm_duty", want.pwm_duty, got.pwm_duty);
			compare_field("power_percent", 8'(want.power_percent), 8'(got.power_percent));
			compare_field("red_led", 8'(want.red_led), 8'(got.red_led));
			compare_field("green_led", 8'(want.green_led), 8'(got.green_led));
			compare_field("blue_led", 8'(want.blue_led), 8'(got.blue_led));
			compare_field("turn_mode", 8'(want.turn_mode), 8'(got.turn_mode));
		endfunction
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            in_valid = 1'b0;
	logic                            in_stall;
	logic                            level_a = 1'b1;
	logic                            level_b = 1'b1;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	logic                            drive_in1;
	logic                            drive_in2;
	logic [7:0]                      pwm_duty;
	logic [6:0]                      power_percent;
	logic                            red_led;
	logic                            green_led;
	logic                            blue_led;
	logic                            turn_mode;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [tbmmc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]                      cfg_data = '0;

	motor_state_tracker tracker;
	int  ticks_sent = 0;
	int  burst_left = 0;
	int  stall_pct = 0;
	bit  hold_req = 1'b0;
	int  hold_left = 0;
	int  run_left = 0;
	bit  run_stalled = 1'b0;
	int  cycles = 0;

	two_button_motor_mode_controller_top DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver: random stall runs, or a long hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			if (run_left == 0) begin
				run_left    = $urandom_range(1, 8);
				run_stalled = ($urandom_range(0, 99) < stall_pct);
			end
			run_left--;
			out_stall <= run_stalled;
		end
	end

	// result beats
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_outputs('{drive_in1, drive_in2, pwm_duty, power_percent,
				red_led, green_led, blue_led, turn_mode});
	end

	// one tick beat; called and returns at a falling edge; sender may idle between bursts
	task automatic send_tick(input bit a, input bit b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) begin
					@(posedge clk);
					@(negedge clk);
				end
			end
		end
		in_valid <= 1'b1;
		level_a  <= a;
		level_b  <= b;
		do @(posedge clk); while (in_stall);
		tracker.note_tick(a, b);
		ticks_sent++;
		burst_left--;
		@(negedge clk);
	endtask

	// buttons held low for the given ticks (B starting lag_b later), then released
	task automatic press(input int hold_a, input int hold_b, input int lag_b, input int rest);
		int span;
		span = (hold_a > lag_b + hold_b) ? hold_a : lag_b + hold_b;
		for (int t = 0; t < span; t++)
			send_tick(!(t < hold_a), !(t >= lag_b && t < lag_b + hold_b));
		repeat (rest) send_tick(1'b1, 1'b1);
	endtask

	task automatic write_reg(input logic [tbmmc_pkg::CFG_IDX_W-1:0] idx,
			input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		tracker.set_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// stop sending and wait until every owed result beat has come out
	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_config(input logic [7:0] qt, input logic [7:0] wt,
			input logic [7:0] step, input logic [7:0] limit);
		write_reg(tbmmc_pkg::REG_QUALIFY_TICKS, qt);
		write_reg(tbmmc_pkg::REG_WINDOW_TICKS, wt);
		write_reg(tbmmc_pkg::REG_POWER_STEP, step);
		write_reg(tbmmc_pkg::REG_POWER_LIMIT, limit);
	endtask

	// mostly well-formed presses with random timing, some aborted presses and noise
	task automatic run_gestures(input int budget);
		int start, kind, qt, wt, ha, hb;
		start = ticks_sent;
		qt = int'(tracker.qual_len);
		wt = int'(tracker.window_len);
		while (ticks_sent - start < budget) begin
			kind = $urandom_range(0, 9);
			ha = qt + 1 + $urandom_range(0, qt + 2);
			hb = qt + 1 + $urandom_range(0, qt + 2);
			case (kind)
				0, 1, 2: press(ha, 0, 0, $urandom_range(qt, 2 * qt + wt + 3));
				3, 4, 5: press(0, hb, 0, $urandom_range(qt, 2 * qt + wt + 3));
				6, 7: press(ha, hb, $urandom_range(0, 2), $urandom_range(qt, 2 * qt + wt + 3));
				8: repeat ($urandom_range(1, 6))
					send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				default: begin
					// released before the first phase completes
					ha = $urandom_range(1, (qt > 0) ? qt : 1);
					if ($urandom_range(0, 1)) press(ha, 0, 0, $urandom_range(1, wt + 2));
					else press(0, ha, 0, $urandom_range(1, wt + 2));
				end
			endcase
		end
		drain();
	endtask

	initial begin
		tracker = new();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: fast qualifier, one-tick window, limit above 100
		set_config(8'd0, 8'd1, 8'd64, 8'd127);
		press(2, 0, 0, 2);   // counterclockwise
		press(0, 2, 0, 2);   // moving, so stop
		press(2, 2, 0, 2);   // to power mode
		press(2, 0, 0, 2);   // raise
		press(2, 0, 0, 2);   // raise, saturates at limit
		press(0, 2, 0, 2);   // lower
		press(0, 2, 0, 2);   // lower, floors at zero
		drain();

		// reset values, light receiver stalls
		stall_pct = 20;
		set_config(tbmmc_pkg::QUALIFY_TICKS_RST, tbmmc_pkg::WINDOW_TICKS_RST,
			tbmmc_pkg::POWER_STEP_RST, tbmmc_pkg::POWER_LIMIT_RST);
		run_gestures(110);

		// smallest settings, receiver holds off long enough to back up the input
		stall_pct = 0;
		set_config(8'd1, 8'd1, 8'd1, 8'd1);
		hold_req = 1'b1;
		run_gestures(120);

		// zero window: flags pile up until a later nonzero window
		stall_pct = 40;
		set_config(8'd0, 8'd0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		run_gestures(50);

		// random settings, including writes to unused indexes
		for (int ph = 0; ph < 3; ph++) begin
			stall_pct = (ph == 0) ? 50 : (ph == 1) ? 80 : 0;
			for (int i = int'(tbmmc_pkg::REG_POWER_LIMIT) + 1;
					i < (1 << tbmmc_pkg::CFG_IDX_W); i++)
				write_reg(i[tbmmc_pkg::CFG_IDX_W-1:0], 8'($urandom_range(0, 255)));
			set_config(8'($urandom_range(1, 6)), 8'($urandom_range(1, 10)),
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
			run_gestures(100);
		end

		// largest qualify and window lengths, one press only
		stall_pct = 10;
		set_config(8'd255, 8'd255, 8'd100, 8'd100);
		press(257, 0, 0, 520);
		drain();

		repeat (5) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
